@@ hw/rtl/plfd_pkg.sv @@
// Shared constants, types and helpers for the preamble/length deframer.
`timescale 1ns / 1ps

package plfd_pkg;

  // Preamble byte, sent twice ahead of every frame
  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_CHECK_MODE      = 1'd0;
  localparam logic [0:0] REG_MAX_PAYLOAD_LEN = 1'd1;

  // Configuration reset values
  localparam logic [1:0]  CHECK_MODE_RST      = 2'd1;
  localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd2048;

  // Check mode codes
  localparam logic [1:0] CHECK_NONE = 2'd0;
  localparam logic [1:0] CHECK_TWO  = 2'd1;
  localparam logic [1:0] CHECK_FOUR = 2'd2;

  // Result field kinds
  localparam logic [2:0] KIND_DEST    = 3'd0;
  localparam logic [2:0] KIND_SRC     = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_CHECK   = 3'd4;
  localparam logic [2:0] KIND_LEN_ERR = 3'd5;

  // One result request
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        last;
  } result_t;

  // Number of check bytes that trail the payload; the unused mode means none
  function automatic logic [2:0] check_count(input logic [1:0] mode);
    logic [2:0] n;
    case (mode)
      CHECK_TWO:  n = 3'd2;
      CHECK_FOUR: n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/preamble_length_frame_deframer.sv @@
// Top level of the preamble and length-field deframer.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_rx_byte) carries received link
//   bytes, one request per byte. The block hunts for two 0x55 bytes, then
//   reports destination and source address bytes, the big-endian 16-bit
//   length, the payload bytes and 0, 2 or 4 check bytes. A length above
//   max_payload_len gives a single length-error result and hunting resumes.
//   Output channel (out_valid / out_stall / out_field_kind / out_field_value
//   / out_frame_last) carries zero or one result request per input byte;
//   out_frame_last marks the final result of a frame.
//   Results: each result is registered in the output register, or in the
//   skid entry while the output waits. Throughput: one byte per cycle while
//   in_stall is low; each byte is classified by combinational phase logic.
//   Stalls: an output register plus one skid entry sit behind the phase
//   logic, so a byte is still taken while one result waits at the output.
//   in_stall rises only once the skid entry is occupied too; it is a
//   register output and does not follow out_stall combinationally.
//   Reset (rst_n low at a clock edge) returns to hunting, empties the
//   output and loads check_mode = 1 and max_payload_len = 2048.
//   Configuration: write cfg_wdata to register cfg_index (0 check_mode,
//   1 max_payload_len) while cfg_wr_en is high; write only while idle.
module preamble_length_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result fields
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_field_kind,
  output logic [15:0] out_field_value,
  output logic        out_frame_last
);

  // Phase codes
  localparam logic [2:0] PH_HUNT0   = 3'd0;
  localparam logic [2:0] PH_HUNT1   = 3'd1;
  localparam logic [2:0] PH_DEST    = 3'd2;
  localparam logic [2:0] PH_SRC     = 3'd3;
  localparam logic [2:0] PH_LENH    = 3'd4;
  localparam logic [2:0] PH_LENL    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CHECK   = 3'd7;

  // Configuration registers
  logic [1:0]  check_mode_r;
  logic [15:0] max_len_r;

  // Frame state
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  len_high_r, len_high_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;

  // Output register and skid entry
  logic                  out_valid_r, out_valid_nxt;
  plfd_pkg::result_t     out_r, out_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  plfd_pkg::result_t     skid_r, skid_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  res_valid;
  plfd_pkg::result_t     res;
  logic [15:0]           full_len;
  logic [2:0]            n_check;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  assign full_len = {len_high_r, in_rx_byte};
  assign n_check  = plfd_pkg::check_count(check_mode_r);

  // Classify one byte and advance the phase
  always_comb begin
    phase_nxt      = phase_r;
    len_high_nxt   = len_high_r;
    bytes_left_nxt = bytes_left_r;
    res_valid      = 1'b0;
    res.kind       = plfd_pkg::KIND_DEST;
    res.value      = {8'd0, in_rx_byte};
    res.last       = 1'b0;
    unique case (phase_r)
      PH_HUNT0: begin
        if (in_rx_byte == plfd_pkg::PREAMBLE_BYTE) phase_nxt = PH_HUNT1;
      end
      PH_HUNT1: begin
        phase_nxt = (in_rx_byte == plfd_pkg::PREAMBLE_BYTE) ? PH_DEST : PH_HUNT0;
      end
      PH_DEST: begin
        phase_nxt = PH_SRC;
        res_valid = 1'b1;
        res.kind  = plfd_pkg::KIND_DEST;
      end
      PH_SRC: begin
        phase_nxt = PH_LENH;
        res_valid = 1'b1;
        res.kind  = plfd_pkg::KIND_SRC;
      end
      PH_LENH: begin
        len_high_nxt = in_rx_byte;
        phase_nxt    = PH_LENL;
      end
      PH_LENL: begin
        res_valid = 1'b1;
        res.value = full_len;
        if (full_len > max_len_r) begin
          // too long: report and drop the frame
          res.kind       = plfd_pkg::KIND_LEN_ERR;
          res.last       = 1'b1;
          bytes_left_nxt = 16'd0;
          phase_nxt      = PH_HUNT0;
        end else begin
          res.kind = plfd_pkg::KIND_LENGTH;
          if (full_len != 16'd0) begin
            bytes_left_nxt = full_len;
            phase_nxt      = PH_PAYLOAD;
          end else if (n_check != 3'd0) begin
            bytes_left_nxt = {13'd0, n_check};
            phase_nxt      = PH_CHECK;
          end else begin
            bytes_left_nxt = 16'd0;
            phase_nxt      = PH_HUNT0;
            res.last       = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.kind  = plfd_pkg::KIND_PAYLOAD;
        if (bytes_left_r > 16'd1) begin
          bytes_left_nxt = bytes_left_r - 16'd1;
        end else if (n_check != 3'd0) begin
          bytes_left_nxt = {13'd0, n_check};
          phase_nxt      = PH_CHECK;
        end else begin
          bytes_left_nxt = 16'd0;
          phase_nxt      = PH_HUNT0;
          res.last       = 1'b1;
        end
      end
      PH_CHECK: begin
        res_valid = 1'b1;
        res.kind  = plfd_pkg::KIND_CHECK;
        if (bytes_left_r > 16'd1) begin
          bytes_left_nxt = bytes_left_r - 16'd1;
        end else begin
          bytes_left_nxt = 16'd0;
          phase_nxt      = PH_HUNT0;
          res.last       = 1'b1;
        end
      end
      default: phase_nxt = PH_HUNT0;
    endcase
  end

  // Steer results into the output register or the skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= plfd_pkg::CHECK_MODE_RST;
      max_len_r    <= plfd_pkg::MAX_PAYLOAD_LEN_RST;
      phase_r      <= PH_HUNT0;
      len_high_r   <= 8'd0;
      bytes_left_r <= 16'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          plfd_pkg::REG_CHECK_MODE:      check_mode_r <= cfg_wdata[1:0];
          plfd_pkg::REG_MAX_PAYLOAD_LEN: max_len_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        len_high_r   <= len_high_nxt;
        bytes_left_r <= bytes_left_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_field_kind  = out_r.kind;
  assign out_field_value = out_r.value;
  assign out_frame_last  = out_r.last;

  // The skid entry is only ever filled behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A frame-ending result always sends the block back to hunting
  a_last_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && res.last) |=> (phase_r == PH_HUNT0))
    else $error("frame end did not return to hunting");

  // Counted phases never run with an empty count
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD || phase_r == PH_CHECK) |-> (bytes_left_r != 16'd0))
    else $error("payload or check phase with zero bytes left");

  // Check phase counts at most four bytes
  a_check_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CHECK) |-> (bytes_left_r <= 16'd4))
    else $error("check byte count out of range");

endmodule
